>>> hdl/cqba_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cqba_pkg
// Shared constants, codes and the classified command word for the checked
// queue and buffer access core.
// ---------------------------------------------------------------------------
package cqba_pkg;

  localparam int NUM_QUEUES_DEF   = 8;
  localparam int QUEUE_DEPTH_DEF  = 16;
  localparam int NUM_BUFFERS_DEF  = 8;
  localparam int BUFFER_WORDS_DEF = 64;
  localparam int WORD_BITS_DEF    = 64;

  localparam int ACTION_W = 3;
  localparam int ID_W     = 3;
  localparam int OFFSET_W = 8;
  localparam int DATA_W   = 64;
  localparam int MASK_W   = 8;

  localparam int QDEPTH_REG_W = 5;
  localparam int BWORDS_REG_W = 7;
  localparam int CFG_DATA_W   = 7;
  localparam int CFG_IDX_W    = 1;

  localparam logic [QDEPTH_REG_W-1:0] QDEPTH_RST = 5'd16;
  localparam logic [BWORDS_REG_W-1:0] BWORDS_RST = 7'd64;

  localparam logic [CFG_IDX_W-1:0] REG_QUEUE_DEPTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_WORDS = 1'b1;

  localparam logic [ACTION_W-1:0] ACT_ENQ   = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_DEQ   = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_WRITE = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_READ  = 3'd3;

  localparam int FIFO_DEPTH = 2;

  typedef enum logic [2:0] {
    OP_FAIL  = 3'd0,
    OP_ENQ   = 3'd1,
    OP_DEQ   = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [ID_W-1:0]     target_id;
    logic [OFFSET_W-1:0] offset;
    logic [DATA_W-1:0]   value;
  } cmd_t;

endpackage
`default_nettype wire

>>> hdl/cqba_ifs.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cqba channel interfaces
// Valid/ready channels for access words in and result words out.
// ---------------------------------------------------------------------------
interface cqba_in_if;
  import cqba_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [ID_W-1:0]     target_id;
  logic [OFFSET_W-1:0] offset;
  logic [DATA_W-1:0]   value;
  logic [MASK_W-1:0]   queue_permission_mask;
  logic [MASK_W-1:0]   write_permission_mask;
  logic [MASK_W-1:0]   read_permission_mask;

  modport source (
    output valid, action, target_id, offset, value,
    output queue_permission_mask, write_permission_mask, read_permission_mask,
    input  ready
  );

  modport sink (
    input  valid, action, target_id, offset, value,
    input  queue_permission_mask, write_permission_mask, read_permission_mask,
    output ready
  );
endinterface

interface cqba_out_if;
  import cqba_pkg::*;

  logic              valid;
  logic              ready;
  logic              success;
  logic [DATA_W-1:0] data_out;

  modport source (output valid, success, data_out, input ready);
  modport sink (input valid, success, data_out, output ready);
endinterface
`default_nettype wire

>>> hdl/cqba_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cqba_front
// Accepts access words, checks target range, permission and offset bound,
// and queues the classified command for the back end.
// ---------------------------------------------------------------------------
module cqba_front #(
  parameter int NUM_QUEUES   = cqba_pkg::NUM_QUEUES_DEF,
  parameter int NUM_BUFFERS  = cqba_pkg::NUM_BUFFERS_DEF,
  parameter int BUFFER_WORDS = cqba_pkg::BUFFER_WORDS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  cqba_in_if.sink                           in_ch,
  input  logic [cqba_pkg::BWORDS_REG_W-1:0] bwords,
  input  logic                              hold,
  output logic                              head_valid,
  output cqba_pkg::cmd_t                    head_cmd,
  input  logic                              pop
);
  import cqba_pkg::*;

  localparam int FP = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FC = $clog2(FIFO_DEPTH + 1);

  cmd_t          fifo_r [FIFO_DEPTH];
  logic [FP-1:0] wr_ptr_r;
  logic [FP-1:0] rd_ptr_r;
  logic [FC-1:0] count_r;

  logic q_ok;
  logic w_ok;
  logic r_ok;
  logic off_ok;
  cmd_t cmd;
  logic push;

  always_comb begin
    off_ok = (int'(in_ch.offset) < int'(bwords)) && (int'(in_ch.offset) < BUFFER_WORDS);
    q_ok   = (int'(in_ch.target_id) < NUM_QUEUES) &&
             in_ch.queue_permission_mask[in_ch.target_id];
    w_ok   = (int'(in_ch.target_id) < NUM_BUFFERS) && off_ok &&
             in_ch.write_permission_mask[in_ch.target_id];
    r_ok   = (int'(in_ch.target_id) < NUM_BUFFERS) && off_ok &&
             in_ch.read_permission_mask[in_ch.target_id];

    cmd.target_id = in_ch.target_id;
    cmd.offset    = in_ch.offset;
    cmd.value     = in_ch.value;
    unique case (in_ch.action)
      ACT_ENQ:   cmd.op = q_ok ? OP_ENQ : OP_FAIL;
      ACT_DEQ:   cmd.op = q_ok ? OP_DEQ : OP_FAIL;
      ACT_WRITE: cmd.op = w_ok ? OP_WRITE : OP_FAIL;
      ACT_READ:  cmd.op = r_ok ? OP_READ : OP_FAIL;
      default:   cmd.op = OP_FAIL;
    endcase
  end

  assign in_ch.ready = (count_r != FC'(FIFO_DEPTH)) && !hold;
  assign push        = in_ch.valid && in_ch.ready;
  assign head_valid  = (count_r != '0);
  assign head_cmd    = fifo_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == FP'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + FP'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == FP'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + FP'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + FC'(1);
      end else if (pop && !push) begin
        count_r <= count_r - FC'(1);
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/cqba_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cqba_back
// Executes classified commands against the ring queues and word buffers,
// clears the buffers after reset and holds the result word.
// ---------------------------------------------------------------------------
module cqba_back #(
  parameter int NUM_QUEUES   = cqba_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH  = cqba_pkg::QUEUE_DEPTH_DEF,
  parameter int NUM_BUFFERS  = cqba_pkg::NUM_BUFFERS_DEF,
  parameter int BUFFER_WORDS = cqba_pkg::BUFFER_WORDS_DEF,
  parameter int WORD_BITS    = cqba_pkg::WORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [cqba_pkg::QDEPTH_REG_W-1:0] qdepth,
  input  logic                              head_valid,
  input  cqba_pkg::cmd_t                    head_cmd,
  output logic                              pop,
  output logic                              clearing,
  cqba_out_if.source                        out_ch
);
  import cqba_pkg::*;

  localparam int QIW        = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int PW         = $clog2(QUEUE_DEPTH);
  localparam int CW         = $clog2(QUEUE_DEPTH + 1);
  localparam int SW         = $clog2(2 * QUEUE_DEPTH);
  localparam int KW         = (SW > 1) ? $clog2(SW) : 1;
  localparam int QMEM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
  localparam int QAW        = $clog2(QMEM_DEPTH);
  localparam int BMEM_DEPTH = NUM_BUFFERS * BUFFER_WORDS;
  localparam int BAW        = (BMEM_DEPTH > 1) ? $clog2(BMEM_DEPTH) : 1;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_RUN   = 3'b010,
    S_MOD   = 3'b100
  } state_t;

  typedef enum logic [1:0] {
    SRC_NONE   = 2'd0,
    SRC_QUEUE  = 2'd1,
    SRC_BUFFER = 2'd2
  } src_t;

  state_t state_r;
  logic [BAW-1:0] clr_addr_r;

  logic [PW-1:0] rd_ptr_r [NUM_QUEUES];
  logic [CW-1:0] cnt_r    [NUM_QUEUES];

  logic [WORD_BITS-1:0] qmem [QMEM_DEPTH];
  logic [WORD_BITS-1:0] bmem [BMEM_DEPTH];
  logic [WORD_BITS-1:0] q_rdata_r;
  logic [WORD_BITS-1:0] b_rdata_r;

  logic [SW-1:0] rem_r;
  logic [KW-1:0] step_r;
  logic          slot_ok_r;

  logic out_valid_r;
  logic ok_r;
  src_t src_r;

  logic [CW-1:0]     d;
  logic [SW-1:0]     d_sw;
  logic [QIW-1:0]    qi;
  logic [PW-1:0]     head;
  logic [CW-1:0]     cnt;
  logic [SW-1:0]     s;
  logic              s_lt_2d;
  logic [PW-1:0]     slot;
  logic [PW-1:0]     head_next;
  logic              enq_ok;
  logic              deq_ok;
  logic              is_enq;
  logic              need_mod;
  logic              out_free;
  logic              fire;
  logic              ok;
  logic [QAW-1:0]    q_addr;
  logic              q_we;
  logic              q_re;
  logic [BAW-1:0]    b_addr;
  logic              b_we;
  logic              b_re;
  logic [2*SW-1:0]   dsh;

  // effective depth, clamped to 1..QUEUE_DEPTH
  always_comb begin
    if (qdepth == '0) begin
      d = CW'(1);
    end else if (int'(qdepth) > QUEUE_DEPTH) begin
      d = CW'(QUEUE_DEPTH);
    end else begin
      d = CW'(qdepth);
    end
  end

  assign d_sw = SW'(d);
  assign qi   = QIW'(head_cmd.target_id);
  assign head = rd_ptr_r[qi];
  assign cnt  = cnt_r[qi];
  assign s    = SW'(head) + SW'(cnt);

  assign s_lt_2d   = {1'b0, s} < {d_sw, 1'b0};
  assign enq_ok    = cnt < d;
  assign deq_ok    = cnt != '0;
  assign head_next = (SW'(head) + SW'(1) >= d_sw) ? '0 : head + PW'(1);

  always_comb begin
    if (slot_ok_r) begin
      slot = PW'(rem_r);
    end else if (s >= d_sw) begin
      slot = PW'(s - d_sw);
    end else begin
      slot = PW'(s);
    end
  end

  assign is_enq   = head_valid && (head_cmd.op == OP_ENQ);
  assign need_mod = is_enq && enq_ok && !slot_ok_r && !s_lt_2d;
  assign out_free = !out_valid_r || out_ch.ready;
  assign fire     = (state_r == S_RUN) && head_valid && out_free && !need_mod;
  assign pop      = fire;
  assign clearing = (state_r == S_CLEAR);

  always_comb begin
    unique case (head_cmd.op)
      OP_ENQ:   ok = enq_ok;
      OP_DEQ:   ok = deq_ok;
      OP_WRITE: ok = 1'b1;
      OP_READ:  ok = 1'b1;
      default:  ok = 1'b0;
    endcase
  end

  assign q_addr = QAW'(int'(qi) * QUEUE_DEPTH +
                       int'((head_cmd.op == OP_ENQ) ? slot : head));
  assign q_we   = fire && (head_cmd.op == OP_ENQ) && enq_ok;
  assign q_re   = fire && (head_cmd.op == OP_DEQ) && deq_ok;

  assign b_addr = clearing ? clr_addr_r
                           : BAW'(int'(head_cmd.target_id) * BUFFER_WORDS +
                                  int'(head_cmd.offset));
  assign b_we   = clearing || (fire && (head_cmd.op == OP_WRITE));
  assign b_re   = fire && (head_cmd.op == OP_READ);

  always_ff @(posedge clk) begin
    if (q_we) begin
      qmem[q_addr] <= head_cmd.value[WORD_BITS-1:0];
    end
    if (q_re) begin
      q_rdata_r <= qmem[q_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      bmem[b_addr] <= clearing ? '0 : head_cmd.value[WORD_BITS-1:0];
    end
    if (b_re) begin
      b_rdata_r <= bmem[b_addr];
    end
  end

  // restoring remainder, one quotient bit a cycle
  assign dsh = {{SW{1'b0}}, d_sw} << step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_addr_r <= '0;
      slot_ok_r  <= 1'b0;
    end else begin
      unique case (state_r)
        S_CLEAR: begin
          if (clr_addr_r == BAW'(BMEM_DEPTH - 1)) begin
            state_r <= S_RUN;
          end else begin
            clr_addr_r <= clr_addr_r + BAW'(1);
          end
        end
        S_RUN: begin
          if (need_mod) begin
            state_r <= S_MOD;
          end
          if (fire) begin
            slot_ok_r <= 1'b0;
          end
        end
        S_MOD: begin
          if (step_r == '0) begin
            slot_ok_r <= 1'b1;
            state_r   <= S_RUN;
          end
        end
        default: state_r <= S_CLEAR;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_RUN) && need_mod) begin
      rem_r  <= s;
      step_r <= KW'(SW - 1);
    end else if (state_r == S_MOD) begin
      if ({{SW{1'b0}}, rem_r} >= dsh) begin
        rem_r <= rem_r - dsh[SW-1:0];
      end
      step_r <= step_r - KW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        rd_ptr_r[i] <= '0;
        cnt_r[i]    <= '0;
      end
    end else if (q_we) begin
      cnt_r[qi] <= cnt + CW'(1);
    end else if (q_re) begin
      cnt_r[qi]    <= cnt - CW'(1);
      rd_ptr_r[qi] <= head_next;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      ok_r        <= 1'b0;
      src_r       <= SRC_NONE;
    end else if (fire) begin
      out_valid_r <= 1'b1;
      ok_r        <= ok;
      if (q_re) begin
        src_r <= SRC_QUEUE;
      end else if (b_re) begin
        src_r <= SRC_BUFFER;
      end else begin
        src_r <= SRC_NONE;
      end
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.success = ok_r;

  always_comb begin
    unique case (src_r)
      SRC_QUEUE:  out_ch.data_out = DATA_W'(q_rdata_r);
      SRC_BUFFER: out_ch.data_out = DATA_W'(b_rdata_r);
      default:    out_ch.data_out = '0;
    endcase
  end

`ifndef SYNTH
  a_fire_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("executed command left no result word");

  a_mod_returns: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOD) && (step_r == '0) |=> (state_r == S_RUN) && slot_ok_r)
    else $error("remainder unit did not hand back a slot");

  a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) && slot_ok_r |-> rem_r < d_sw)
    else $error("enqueue slot not below depth");

  a_data_on_success: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (src_r != SRC_NONE) |-> ok_r)
    else $error("read data on a failed access");
`endif

endmodule
`default_nettype wire

>>> hdl/checked_queue_and_buffer_access_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// checked_queue_and_buffer_access_core
// Permission-checked enqueue/dequeue on ring queues and read/write on word
// buffers; one result word per access word.
// ---------------------------------------------------------------------------
//  channel | dir | handshake    | payload
//  in_ch   | in  | valid/ready  | action, target_id, offset, value, 3 masks
//  out_ch  | out | valid/ready  | success, data_out
//  cfg_*   | in  | cfg_we       | cfg_index, cfg_wdata
//
//  One word a cycle sustained while out_ch is ready and no enqueue is held
//  for the remainder unit; an accepted access word waits in the command
//  queue, executes, and its result word is held in the output register
//  until out_ch takes it. An enqueue whose ring sum reaches twice the depth
//  (read pointer left beyond a lowered depth) is held while the remainder
//  unit reduces the sum. After reset all NUM_BUFFERS*BUFFER_WORDS buffer
//  words (512 by default) are cleared, with in_ch.ready low.
//  A two-entry command queue lets intake run while out_ch is stalled.
// ---------------------------------------------------------------------------
module checked_queue_and_buffer_access_core #(
  parameter int NUM_QUEUES   = cqba_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH  = cqba_pkg::QUEUE_DEPTH_DEF,
  parameter int NUM_BUFFERS  = cqba_pkg::NUM_BUFFERS_DEF,
  parameter int BUFFER_WORDS = cqba_pkg::BUFFER_WORDS_DEF,
  parameter int WORD_BITS    = cqba_pkg::WORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  cqba_in_if.sink                         in_ch,
  cqba_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [cqba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cqba_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import cqba_pkg::*;

  logic [QDEPTH_REG_W-1:0] qdepth_r;
  logic [BWORDS_REG_W-1:0] bwords_r;

  logic head_valid;
  cmd_t head_cmd;
  logic pop;
  logic clearing;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qdepth_r <= QDEPTH_RST;
      bwords_r <= BWORDS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_QUEUE_DEPTH:  qdepth_r <= cfg_wdata[QDEPTH_REG_W-1:0];
        REG_BUFFER_WORDS: bwords_r <= cfg_wdata[BWORDS_REG_W-1:0];
        default:          ;
      endcase
    end
  end

  cqba_front #(
    .NUM_QUEUES   (NUM_QUEUES),
    .NUM_BUFFERS  (NUM_BUFFERS),
    .BUFFER_WORDS (BUFFER_WORDS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .bwords     (bwords_r),
    .hold       (clearing),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop)
  );

  cqba_back #(
    .NUM_QUEUES   (NUM_QUEUES),
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .NUM_BUFFERS  (NUM_BUFFERS),
    .BUFFER_WORDS (BUFFER_WORDS),
    .WORD_BITS    (WORD_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .qdepth     (qdepth_r),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .clearing   (clearing),
    .out_ch     (out_ch)
  );

endmodule
`default_nettype wire
